FILE: design/apsp_pkg.sv
// shared types and constants of the all-pairs shortest path block
`default_nettype none

package apsp_pkg;

  localparam int NODE_FIELD_W = 7;
  localparam int WEIGHT_W     = 16;
  localparam int LEN_W        = 23;
  localparam int DIST_W       = 24;
  localparam int CFG_W        = 8;
  localparam int STATUS_W     = 2;
  localparam int MODE_W       = 2;

  // unreachable marker and saturation limit of stored distances
  localparam logic [DIST_W-1:0] DIST_NONE = 24'hFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_SAT  = 24'h7F_FFFF;

  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 8'd128;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_SOLVE = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_NODE   = 2'd1,
    ST_NOT_SOLVED = 2'd2
  } status_e;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [NODE_FIELD_W-1:0] node_a;
    logic [NODE_FIELD_W-1:0] node_b;
    logic [WEIGHT_W-1:0]     edge_weight;
  } req_t;

  typedef struct packed {
    logic [LEN_W-1:0]    path_length;
    logic                reachable;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

`default_nettype wire

FILE: design/apsp_stream_if.sv
// valid/ready stream interface carrying one payload per transfer
`default_nettype none

interface apsp_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

FILE: design/all_pairs_shortest_paths.sv
// all-pairs shortest path engine over a distance matrix held in one ram
//
// req_i takes requests (clear, add edge, solve, query); rsp_o returns exactly
// one response per request, in order. node_count is written on cfg_we_i; the
// user must write it only while the block is idle (not enforced by the block);
// 0 acts as 1 and values above MAX_NODES act as MAX_NODES. one request is
// worked on at a time; req_i.ready is high only while idle, and a new request
// is taken even while the last response still sits in the output register
// waiting for rsp_o.ready. the single write port and the registered ram read
// set the steps: an out-of-range node or a query before solve goes straight
// to the response, a query reads and then answers, an add edge does two
// read-modify-writes, a clear writes one matrix entry per cycle over all
// MAX_NODES*MAX_NODES entries, and a solve does one relaxation per cycle over
// the n nodes in use, a skipped row passing only through S_SIK, S_SDIK and
// S_SDRAIN. req_i.ready rises with response valid. reset starts the same
// clearing pass with req_i.ready low and no response; the config register
// still takes writes. a stalled receiver holds the response in the output
// register; a finished request then waits in its last step until it frees up.
`default_nettype none

module all_pairs_shortest_paths #(
  parameter int MAX_NODES = 128
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [apsp_pkg::CFG_W-1:0] cfg_wdata_i,
  apsp_stream_if.sink               req_i,
  apsp_stream_if.source             rsp_o
);

  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int CMP_W  = (CNT_W > apsp_pkg::CFG_W) ? CNT_W : apsp_pkg::CFG_W;
  localparam int ADDR_W = 2 * NODE_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int DW     = apsp_pkg::DIST_W;
  localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(MAX_NODES - 1);
  localparam logic [CMP_W-1:0]  MAX_CMP   = CMP_W'(MAX_NODES);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_CLR    = 13'b0000000000010,
    S_AR1    = 13'b0000000000100,
    S_AW1    = 13'b0000000001000,
    S_AR2    = 13'b0000000010000,
    S_AW2    = 13'b0000000100000,
    S_QR     = 13'b0000001000000,
    S_QW     = 13'b0000010000000,
    S_SIK    = 13'b0000100000000,
    S_SDIK   = 13'b0001000000000,
    S_SROW   = 13'b0010000000000,
    S_SDRAIN = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_e;

  // control state
  state_e                      state_q, state_d;
  logic [apsp_pkg::CFG_W-1:0]  node_count_q;
  logic                        solved_q, solved_d;
  logic                        clr_item_q, clr_item_d;
  logic [NODE_W-1:0]           k_q, k_d, i_q, i_d, j_q, j_d;
  logic                        wb_v_q, wb_v_d;
  logic                        rsp_valid_q, rsp_valid_d;

  // payload registers
  logic [NODE_W-1:0]              a_q, a_d, b_q, b_d, last_q, last_d, wb_j_q, wb_j_d;
  logic [apsp_pkg::WEIGHT_W-1:0]  w_q, w_d;
  logic [DW-1:0]                  dik_q, dik_d;
  apsp_pkg::rsp_t                 res_q, res_d, rsp_data_q, rsp_data_d;

  // distance matrix ram, one write and two read ports
  logic [DW-1:0]     mem [DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, ra, rb;
  logic [DW-1:0]     mem_wdata, rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= mem[ra];
    rd_b_q <= mem[rb];
  end

  // effective node count and range check of the incoming request
  logic [CMP_W-1:0]  cnt_ext, n_eff, a_ext, b_ext;
  logic [NODE_W-1:0] n_last;
  logic              bad_node, req_fire, out_free;

  always_comb begin
    cnt_ext = CMP_W'(node_count_q);
    if (cnt_ext == '0) begin
      n_eff = CMP_W'(1);
    end else if (cnt_ext > MAX_CMP) begin
      n_eff = MAX_CMP;
    end else begin
      n_eff = cnt_ext;
    end
    n_last   = NODE_W'(n_eff - CMP_W'(1));
    a_ext    = CMP_W'(req_i.data.node_a);
    b_ext    = CMP_W'(req_i.data.node_b);
    bad_node = (a_ext >= n_eff) || (b_ext >= n_eff);
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_data_q;

  // relaxation datapath: dkj on port a, dij on port b
  logic [DW-1:0] w_ext, relax_sum, relax_sat;
  assign w_ext     = DW'(w_q);
  assign relax_sum = DW'(dik_q[apsp_pkg::LEN_W-1:0]) + DW'(rd_a_q[apsp_pkg::LEN_W-1:0]);
  assign relax_sat = (relax_sum > apsp_pkg::DIST_SAT) ? apsp_pkg::DIST_SAT : relax_sum;

  always_comb begin
    state_d     = state_q;
    solved_d    = solved_q;
    clr_item_d  = clr_item_q;
    k_d         = k_q;
    i_d         = i_q;
    j_d         = j_q;
    wb_v_d      = 1'b0;
    wb_j_d      = wb_j_q;
    a_d         = a_q;
    b_d         = b_q;
    w_d         = w_q;
    last_d      = last_q;
    dik_d       = dik_q;
    res_d       = res_q;
    rsp_data_d  = rsp_data_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    mem_we      = 1'b0;
    mem_waddr   = {a_q, b_q};
    mem_wdata   = w_ext;
    ra          = {a_q, b_q};
    rb          = {i_q, j_q};

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          a_d   = NODE_W'(a_ext);
          b_d   = NODE_W'(b_ext);
          w_d   = req_i.data.edge_weight;
          res_d = '0;
          case (req_i.data.mode)
            apsp_pkg::MODE_CLEAR: begin
              solved_d   = 1'b0;
              clr_item_d = 1'b1;
              i_d        = '0;
              j_d        = '0;
              state_d    = S_CLR;
            end
            apsp_pkg::MODE_SOLVE: begin
              k_d     = '0;
              i_d     = '0;
              last_d  = n_last;
              state_d = S_SIK;
            end
            apsp_pkg::MODE_ADD: begin
              if (bad_node) begin
                res_d.status = apsp_pkg::ST_BAD_NODE;
                state_d      = S_DONE;
              end else begin
                solved_d = 1'b0;
                state_d  = S_AR1;
              end
            end
            apsp_pkg::MODE_QUERY: begin
              if (bad_node) begin
                res_d.status = apsp_pkg::ST_BAD_NODE;
                state_d      = S_DONE;
              end else if (!solved_q) begin
                res_d.status = apsp_pkg::ST_NOT_SOLVED;
                state_d      = S_DONE;
              end else begin
                state_d = S_QR;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_CLR: begin
        // sweep every entry: zero on the diagonal, unreachable elsewhere
        mem_we    = 1'b1;
        mem_waddr = {i_q, j_q};
        mem_wdata = (i_q == j_q) ? '0 : apsp_pkg::DIST_NONE;
        if (j_q == NODE_LAST) begin
          j_d = '0;
          if (i_q == NODE_LAST) begin
            state_d = clr_item_q ? S_DONE : S_IDLE;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_AR1: begin
        ra      = {a_q, b_q};
        state_d = S_AW1;
      end
      S_AW1: begin
        mem_we    = (w_ext < rd_a_q);
        mem_waddr = {a_q, b_q};
        state_d   = S_AR2;
      end
      S_AR2: begin
        ra      = {b_q, a_q};
        state_d = S_AW2;
      end
      S_AW2: begin
        mem_we    = (w_ext < rd_a_q);
        mem_waddr = {b_q, a_q};
        state_d   = S_DONE;
      end
      S_QR: begin
        ra      = {a_q, b_q};
        state_d = S_QW;
      end
      S_QW: begin
        if (rd_a_q != apsp_pkg::DIST_NONE) begin
          res_d.path_length = rd_a_q[apsp_pkg::LEN_W-1:0];
          res_d.reachable   = 1'b1;
        end
        state_d = S_DONE;
      end
      S_SIK: begin
        ra      = {i_q, k_q};
        state_d = S_SDIK;
      end
      S_SDIK: begin
        dik_d = rd_a_q;
        j_d   = '0;
        // an unreachable d(i,k) relaxes nothing in this row
        state_d = (rd_a_q == apsp_pkg::DIST_NONE) ? S_SDRAIN : S_SROW;
      end
      S_SROW: begin
        ra     = {k_q, j_q};
        rb     = {i_q, j_q};
        wb_v_d = 1'b1;
        wb_j_d = j_q;
        if (j_q == last_q) begin
          state_d = S_SDRAIN;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_SDRAIN: begin
        // last write of the row lands here, before the next d(i,k) read
        if (i_q == last_q) begin
          i_d = '0;
          if (k_q == last_q) begin
            solved_d = 1'b1;
            state_d  = S_DONE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_SIK;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_SIK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_data_d  = res_q;
          clr_item_d  = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // relaxation write-back, in the cycle after the row reads
    if (wb_v_q && (rd_a_q != apsp_pkg::DIST_NONE) && (relax_sat < rd_b_q)) begin
      mem_we    = 1'b1;
      mem_waddr = {i_q, wb_j_q};
      mem_wdata = relax_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      node_count_q <= apsp_pkg::NODE_COUNT_RESET;
      solved_q     <= 1'b0;
      clr_item_q   <= 1'b0;
      k_q          <= '0;
      i_q          <= '0;
      j_q          <= '0;
      wb_v_q       <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      solved_q    <= solved_d;
      clr_item_q  <= clr_item_d;
      k_q         <= k_d;
      i_q         <= i_d;
      j_q         <= j_d;
      wb_v_q      <= wb_v_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    w_q        <= w_d;
    last_q     <= last_d;
    wb_j_q     <= wb_j_d;
    dik_q      <= dik_d;
    res_q      <= res_d;
    rsp_data_q <= rsp_data_d;
  end

endmodule

`default_nettype wire

FILE: design/apsp_checker.sv
// port-level checker of the all-pairs shortest path block, with its bind
`default_nettype none

module apsp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_i,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input apsp_pkg::rsp_t rsp_data_i
);

  logic       req_fire, rsp_fire;
  logic [1:0] pending_q, pending_d;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (req_fire && !rsp_fire) begin
      pending_d = pending_q + 2'd1;
    end else if (!req_fire && rsp_fire) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // a stalled response holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("response changed while stalled");

  // every response answers an earlier request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pending_q != 2'd0)
    else $error("response without request");

  // at most one request in work plus one response parked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |-> pending_q <= 2'd1)
    else $error("request taken with two outstanding");

  // the clearing pass after reset keeps requests out
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !req_ready_i)
    else $error("request accepted during reset clear");

  // error responses carry no distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.status != apsp_pkg::ST_OK)
      |-> (rsp_data_i.path_length == '0) && !rsp_data_i.reachable)
    else $error("error response with distance");

endmodule

bind all_pairs_shortest_paths apsp_checker u_apsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

`default_nettype wire

FILE: dv/all_pairs_shortest_paths_tb.sv
// self-checking testbench of the all-pairs shortest path block
`timescale 1ns / 1ps

module all_pairs_shortest_paths_tb;

  localparam int MAX_N           = 128;
  localparam int DIST_BITS       = apsp_pkg::DIST_W;
  localparam int MODE_BITS       = apsp_pkg::MODE_W;
  localparam int CFG_BITS        = apsp_pkg::CFG_W;
  // the limit covers the slowest correct run (reset clear, matrix clears, two
  // sparse solves over all nodes, stalls and gaps)
  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_ITEMS    = 700;

  // distance predictor and store of expected responses
  class apsp_scoreboard;
    bit [DIST_BITS-1:0]     dmat [MAX_N*MAX_N];
    bit                     solved;
    logic [CFG_BITS-1:0]    node_cnt;
    apsp_pkg::rsp_t         expected_rsp [$];
    int unsigned            mode_cnt [4];
    int unsigned            checked;
    int unsigned            errors;

    function new();
      node_cnt = apsp_pkg::NODE_COUNT_RESET;
      clear_graph();
    endfunction

    function void clear_graph();
      for (int i = 0; i < MAX_N; i++)
        for (int j = 0; j < MAX_N; j++)
          dmat[i*MAX_N+j] = (i == j) ? '0 : apsp_pkg::DIST_NONE;
      solved = 0;
    endfunction

    // 0 acts as one node, anything above the matrix size as the full matrix
    function int unsigned nodes_in_use();
      if (node_cnt == 0) return 1;
      if (node_cnt > MAX_N) return MAX_N;
      return 32'(node_cnt);
    endfunction

    // floyd-warshall in place, relaxing only through nodes in use
    function void solve_graph(int unsigned n);
      int unsigned dik, dkj, sum;
      for (int unsigned k = 0; k < n; k++)
        for (int unsigned i = 0; i < n; i++) begin
          dik = 32'(dmat[i*MAX_N+k]);
          if (dik == apsp_pkg::DIST_NONE) continue;
          for (int unsigned j = 0; j < n; j++) begin
            dkj = 32'(dmat[k*MAX_N+j]);
            if (dkj == apsp_pkg::DIST_NONE) continue;
            sum = dik + dkj;
            if (sum > apsp_pkg::DIST_SAT) sum = apsp_pkg::DIST_SAT;
            if (sum < dmat[i*MAX_N+j]) dmat[i*MAX_N+j] = DIST_BITS'(sum);
          end
        end
      solved = 1;
    endfunction

    function void note_request(apsp_pkg::req_t r);
      int unsigned    n, a, b, w;
      apsp_pkg::rsp_t e;
      e = '0;
      n = nodes_in_use();
      a = 32'(r.node_a);
      b = 32'(r.node_b);
      w = 32'(r.edge_weight);
      mode_cnt[r.mode]++;
      case (r.mode)
        apsp_pkg::MODE_CLEAR: clear_graph();
        apsp_pkg::MODE_SOLVE: solve_graph(n);
        default: begin
          // range check wins over the not-solved check
          if (a >= n || b >= n) begin
            e.status = apsp_pkg::ST_BAD_NODE;
          end else if (r.mode == apsp_pkg::MODE_ADD) begin
            // parallel edges keep the least weight, diagonal stays zero
            if (w < dmat[a*MAX_N+b]) dmat[a*MAX_N+b] = DIST_BITS'(w);
            if (w < dmat[b*MAX_N+a]) dmat[b*MAX_N+a] = DIST_BITS'(w);
            solved = 0;
          end else if (!solved) begin
            e.status = apsp_pkg::ST_NOT_SOLVED;
          end else if (dmat[a*MAX_N+b] != apsp_pkg::DIST_NONE) begin
            e.path_length = dmat[a*MAX_N+b][apsp_pkg::LEN_W-1:0];
            e.reachable   = 1'b1;
          end
        end
      endcase
      expected_rsp = {expected_rsp, e};
    endfunction

    function void check_response(apsp_pkg::rsp_t got);
      apsp_pkg::rsp_t want;
      if (expected_rsp.size() == 0) begin
        $error("response with no request waiting: path_length %0d reachable %0d status %0d",
               got.path_length, got.reachable, got.status);
        errors++;
        return;
      end
      want = expected_rsp.pop_front();
      checked++;
      if (got.path_length !== want.path_length) begin
        $error("path_length mismatch: expected %0d, actual %0d",
               want.path_length, got.path_length);
        errors++;
      end
      if (got.reachable !== want.reachable) begin
        $error("reachable mismatch: expected %0d, actual %0d", want.reachable, got.reachable);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;

  apsp_stream_if #(.payload_t(apsp_pkg::req_t)) req_if ();
  apsp_stream_if #(.payload_t(apsp_pkg::rsp_t)) rsp_if ();

  apsp_scoreboard sb = new();

  // idling controls, set per phase by the stimulus
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          hold_off_req;
  int unsigned cycle_cnt;

  all_pairs_shortest_paths #(
    .MAX_NODES(MAX_N)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // hard stop if the block hangs
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // response side: ready changes at the falling edge, random stall bursts
  // and one long hold-off on request from the stimulus
  initial begin
    int unsigned stall;
    stall        = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        stall        = HOLD_OFF_CYCLES;
        hold_off_req = 0;
      end else if (stall == 0 && rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 14);
      end
      if (stall > 0) begin
        rsp_if.ready = 1'b0;
        stall--;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  // every accepted response is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      sb.check_response(rsp_if.data);
  end

  // offer one request, with an optional gap first; returns at the accepting edge
  // with valid still high, so a following request can go out back to back
  task automatic send_request(input logic [MODE_BITS-1:0] m, input int unsigned a,
                              input int unsigned b, input int unsigned w);
    apsp_pkg::req_t r;
    int unsigned    gap;
    r.mode        = m;
    r.node_a      = a[apsp_pkg::NODE_FIELD_W-1:0];
    r.node_b      = b[apsp_pkg::NODE_FIELD_W-1:0];
    r.edge_weight = w[apsp_pkg::WEIGHT_W-1:0];
    gap = (tx_idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.data  = r;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(r);
  endtask

  // lower valid and wait until every response is back and the block is idle
  task automatic drain;
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // node_count is only changed while nothing is in flight
  task automatic write_node_count(input logic [CFG_BITS-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    sb.node_cnt = v;
  endtask

  // mostly short edges so paths combine, sometimes the full weight range
  function automatic int unsigned pick_weight();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
  endfunction

  initial begin
    int unsigned         rand_sent, phase_end, phase, n, cnt;
    bit                  final_part;
    logic [CFG_BITS-1:0] cfg;

    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    tx_idle_on   = 1;
    rx_idle_on   = 1;
    hold_off_req = 0;
    cycle_cnt    = 0;
    rand_sent    = 0;
    phase        = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, full node count from reset
    send_request(apsp_pkg::MODE_QUERY, 0, 1, 0);          // query before any solve
    send_request(apsp_pkg::MODE_QUERY, 127, 0, 65535);
    send_request(apsp_pkg::MODE_ADD, 127, 0, 65535);      // top node, largest weight
    send_request(apsp_pkg::MODE_ADD, 0, 127, 5);          // parallel edge, smaller wins
    send_request(apsp_pkg::MODE_ADD, 127, 0, 100);        // parallel edge, larger ignored
    send_request(apsp_pkg::MODE_ADD, 64, 64, 7);          // self loop keeps zero diagonal
    send_request(apsp_pkg::MODE_ADD, 1, 64, 0);           // zero weight
    send_request(apsp_pkg::MODE_SOLVE, 127, 127, 65535);  // sparse solve over all nodes
    send_request(apsp_pkg::MODE_QUERY, 0, 127, 0);
    send_request(apsp_pkg::MODE_QUERY, 127, 64, 0);       // unreachable target
    send_request(apsp_pkg::MODE_QUERY, 64, 64, 0);
    send_request(apsp_pkg::MODE_QUERY, 1, 64, 0);
    send_request(apsp_pkg::MODE_ADD, 0, 1, 65535);        // add drops the solved flag
    send_request(apsp_pkg::MODE_QUERY, 0, 1, 0);

    // node count zero acts as a single node
    write_node_count(8'd0);
    send_request(apsp_pkg::MODE_ADD, 0, 1, 3);            // second endpoint out of range
    send_request(apsp_pkg::MODE_QUERY, 1, 0, 0);          // range error before not-solved
    send_request(apsp_pkg::MODE_QUERY, 0, 0, 0);
    send_request(apsp_pkg::MODE_SOLVE, 0, 0, 0);
    send_request(apsp_pkg::MODE_QUERY, 0, 0, 0);
    send_request(apsp_pkg::MODE_CLEAR, 127, 127, 65535);

    // all ones acts as the full matrix
    write_node_count(8'hFF);
    send_request(apsp_pkg::MODE_QUERY, 127, 127, 0);
    send_request(apsp_pkg::MODE_ADD, 127, 126, 16'h8000);
    send_request(apsp_pkg::MODE_SOLVE, 0, 0, 0);
    send_request(apsp_pkg::MODE_QUERY, 126, 127, 0);
    send_request(apsp_pkg::MODE_QUERY, 0, 126, 0);

    // random phases, small graphs so solves stay cheap
    while (rand_sent < RANDOM_ITEMS) begin
      final_part = (rand_sent >= RANDOM_ITEMS * 4 / 5);
      case ($urandom_range(0, 9))
        0:       cfg = 8'd1;
        1:       cfg = 8'd16;
        default: cfg = CFG_BITS'($urandom_range(2, 9));
      endcase
      write_node_count(cfg);
      tx_idle_on = !final_part && ($urandom_range(0, 3) != 0);
      rx_idle_on = !final_part && ($urandom_range(0, 3) != 0);
      n = sb.nodes_in_use();

      // keeping the old matrix checks nodes left over from a larger count
      if ($urandom_range(0, 1) == 1) begin
        send_request(apsp_pkg::MODE_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127),
                     $urandom);
        rand_sent++;
      end

      // long receiver hold-off with requests offered back to back
      if (phase == 3) begin
        tx_idle_on   = 0;
        hold_off_req = 1;
        repeat (30) begin
          send_request($urandom_range(0, 1) ? apsp_pkg::MODE_ADD : apsp_pkg::MODE_QUERY,
                       $urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_weight());
          rand_sent++;
        end
      end

      phase_end = rand_sent + $urandom_range(30, 70);
      while (rand_sent < phase_end) begin
        if ($urandom_range(0, 4) != 0) begin
          // well-formed: load edges, usually solve, then query
          cnt = $urandom_range(1, 2 * n + 2);
          repeat (cnt) begin
            send_request(apsp_pkg::MODE_ADD, $urandom_range(0, n - 1),
                         $urandom_range(0, n - 1), pick_weight());
            rand_sent++;
          end
          if ($urandom_range(0, 6) != 0) begin
            send_request(apsp_pkg::MODE_SOLVE, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom);
            rand_sent++;
          end
          cnt = $urandom_range(2, 12);
          repeat (cnt) begin
            // now and then one node just past the count in use
            send_request(apsp_pkg::MODE_QUERY, $urandom_range(0, n - 1),
                         ($urandom_range(0, 9) == 0) ? n : $urandom_range(0, n - 1),
                         $urandom);
            rand_sent++;
          end
        end else begin
          // noise: any mode and any node, clears kept rare since they are slow
          send_request(($urandom_range(0, 39) == 0) ? apsp_pkg::MODE_CLEAR
                                                    : MODE_BITS'($urandom_range(1, 3)),
                       $urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(0, n),
                       $urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(0, n),
                       $urandom);
          rand_sent++;
        end
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk_i);

    $display("covered %0d requests: %0d clear, %0d add, %0d solve, %0d query; %0d checked",
             sb.mode_cnt[0] + sb.mode_cnt[1] + sb.mode_cnt[2] + sb.mode_cnt[3],
             sb.mode_cnt[0], sb.mode_cnt[1], sb.mode_cnt[2], sb.mode_cnt[3], sb.checked);
    $display("%0d random phases, node counts 0 to 255, %0d-cycle hold-off, %0d cycles",
             phase, HOLD_OFF_CYCLES, cycle_cnt);
    if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
